FILE: rtl/core/region_weighted_chi_square_macros.svh
// assertion helpers for the chi-square block
`ifndef REGION_WEIGHTED_CHI_SQUARE_MACROS_SVH
`define REGION_WEIGHTED_CHI_SQUARE_MACROS_SVH

// flags a condition that must never hold outside reset
`define RWCS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// flags a condition that must hold in the cycle after a trigger
`define RWCS_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/core/rwcs_pkg.sv
`default_nettype none
package rwcs_pkg;

  localparam int MAX_REGIONS_SIDE = 8;
  localparam int MAX_IMAGE_SIDE   = 1024;
  localparam int REG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 11;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REGION_SIZE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_EXTRA_REGION = 3'd6;

  localparam logic [62:0] SUM_MAX = {63{1'b1}};

  typedef struct packed {
    logic signed [23:0] model_value;
    logic signed [23:0] observed_value;
    logic [15:0]        pixel_weight;
  } in_data_t;

  typedef struct packed {
    logic [2:0]  region_col;
    logic [2:0]  region_row;
    logic [62:0] chi_square;
    logic        last_of_run;
  } out_data_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [10:0] region_size;
    logic [9:0]  margin;
    logic [9:0]  offset_x;
    logic [9:0]  offset_y;
    logic        extra_region;
  } cfg_t;

  typedef struct packed {
    logic [47:0] contrib;
    logic [7:0]  x_mask;
    logic [7:0]  y_mask;
    logic        frame_end;
    logic [3:0]  nx;
    logic [3:0]  ny;
  } job_t;

  function automatic logic [2:0] lsb_idx(input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (m[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/region_weighted_chi_square.sv
// Weighted chi-square per image region. Pixels enter in raster order, one request per cycle
// while the front pipeline (difference, square, weight product: three stages) has room in a
// four-entry job queue. The back end takes one job at a time from the queue, then updates
// the region store one covered region at a time (read, then saturating add and write); the
// front keeps taking pixels while the back end works, as long as the queue has room. After
// the last pixel of a frame every region sum is sent in row-major order, and the store is
// cleared at once by its valid bits. No clearing pass follows reset.
`default_nettype none
`include "region_weighted_chi_square_macros.svh"
module region_weighted_chi_square (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rwcs_pkg::in_data_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rwcs_pkg::out_data_t      out_data,
  input  wire logic                cfg_write_en,
  input  wire logic [rwcs_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [rwcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  rwcs_pkg::cfg_t  cfg_r;
  rwcs_pkg::job_t  push_job, pop_job;
  logic            q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 11'd100;
      cfg_r.image_height <= 11'd100;
      cfg_r.region_size  <= 11'd25;
      cfg_r.margin       <= 10'd2;
      cfg_r.offset_x     <= 10'd0;
      cfg_r.offset_y     <= 10'd0;
      cfg_r.extra_region <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        rwcs_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        rwcs_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        rwcs_pkg::REG_REGION_SIZE:  cfg_r.region_size  <= cfg_data;
        rwcs_pkg::REG_MARGIN:       cfg_r.margin       <= cfg_data[9:0];
        rwcs_pkg::REG_OFFSET_X:     cfg_r.offset_x     <= cfg_data[9:0];
        rwcs_pkg::REG_OFFSET_Y:     cfg_r.offset_y     <= cfg_data[9:0];
        rwcs_pkg::REG_EXTRA_REGION: cfg_r.extra_region <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rwcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (q_push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  rwcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  rwcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `RWCS_NEVER(a_no_push_full, clk, rst_n, q_push && q_full, "job queue overflow")
  `RWCS_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_empty, "job queue underflow")
  `RWCS_NEXT(a_stall_on_full, clk, rst_n, q_full && !q_pop, q_full || !in_stall, "queue drained")

endmodule
`default_nettype wire

FILE: rtl/core/rwcs_front.sv
`default_nettype none
module rwcs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rwcs_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rwcs_pkg::in_data_t in_data,
  output logic                  push,
  output rwcs_pkg::job_t        push_job,
  input  wire logic             q_full
);

  logic [9:0]  col_r, col_nxt, row_r, row_nxt;
  logic [10:0] w_eff, h_eff, s_eff;
  logic [3:0]  nx, ny;
  logic [7:0]  xm, ym;
  logic        adv, acc, col_last, row_last;

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic [24:0] s1_ad_r;
  logic [15:0] s1_w_r, s2_w_r;
  logic [48:0] s2_sq_r;
  rwcs_pkg::job_t s1_job_r, s2_job_r, s3_job_r, s3_job_nxt;
  logic signed [24:0] diff;
  logic [64:0] prod;

  function automatic logic [10:0] clamp_side(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'(rwcs_pkg::MAX_IMAGE_SIDE)) r = 11'(rwcs_pkg::MAX_IMAGE_SIDE);
    return r;
  endfunction

  function automatic logic [3:0] count_regions(input logic [10:0] side, input logic [10:0] s,
                                               input logic extra);
    logic [4:0] q;
    logic [16:0] ks;
    q = 5'd0;
    for (int k = 1; k <= rwcs_pkg::MAX_REGIONS_SIDE; k++) begin
      ks = 17'(k) * {6'd0, s};
      if (ks <= {6'd0, side}) q = q + 5'd1;
    end
    q = q + {4'd0, extra};
    if (q > 5'(rwcs_pkg::MAX_REGIONS_SIDE)) q = 5'(rwcs_pkg::MAX_REGIONS_SIDE);
    return q[3:0];
  endfunction

  function automatic logic [7:0] cover_mask(input logic [9:0] pos, input logic [10:0] side,
                                            input logic [10:0] s, input logic [9:0] offs,
                                            input logic [9:0] m, input logic [3:0] n);
    logic [7:0] r;
    logic signed [17:0] lo, hi, p, sd;
    r  = 8'd0;
    p  = $signed({8'd0, pos});
    sd = $signed({7'd0, side});
    for (int k = 0; k < rwcs_pkg::MAX_REGIONS_SIDE; k++) begin
      lo = $signed(18'(k) * {7'd0, s}) - $signed({8'd0, offs}) - $signed({8'd0, m});
      hi = lo + $signed({7'd0, s}) + $signed({7'd0, m, 1'b0});
      r[k] = (p >= lo) && (p < hi) && (p < sd) && (4'(k) < n);
    end
    return r;
  endfunction

  assign w_eff = clamp_side(cfg.image_width);
  assign h_eff = clamp_side(cfg.image_height);
  assign s_eff = (cfg.region_size == 11'd0) ? 11'd1 : cfg.region_size;
  assign nx    = count_regions(w_eff, s_eff, cfg.extra_region);
  assign ny    = count_regions(h_eff, s_eff, cfg.extra_region);
  assign xm    = cover_mask(col_r, w_eff, s_eff, cfg.offset_x, cfg.margin, nx);
  assign ym    = cover_mask(row_r, h_eff, s_eff, cfg.offset_y, cfg.margin, ny);

  assign adv      = !s3_v_r || !q_full;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;
  assign push     = s3_v_r && !q_full;
  assign push_job = s3_job_r;

  assign col_last = ({1'b0, col_r} + 11'd1) >= w_eff;
  assign row_last = ({1'b0, row_r} + 11'd1) >= h_eff;
  assign diff     = 25'(in_data.model_value) - 25'(in_data.observed_value);
  assign prod     = s2_sq_r * s2_w_r;

  always_comb begin
    s3_job_nxt         = s2_job_r;
    s3_job_nxt.contrib = prod[63:16];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (!col_last) begin
        col_nxt = col_r + 10'd1;
      end else begin
        col_nxt = 10'd0;
        row_nxt = row_last ? 10'd0 : row_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 10'd0;
      row_r  <= 10'd0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) begin
        s1_v_r <= acc;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ad_r            <= diff[24] ? 25'(-diff) : 25'(diff);
      s1_w_r             <= in_data.pixel_weight;
      s1_job_r.contrib   <= 48'd0;
      s1_job_r.x_mask    <= xm;
      s1_job_r.y_mask    <= ym;
      s1_job_r.frame_end <= col_last && row_last;
      s1_job_r.nx        <= nx;
      s1_job_r.ny        <= ny;
      s2_sq_r            <= 49'({24'd0, s1_ad_r} * {24'd0, s1_ad_r});
      s2_w_r             <= s1_w_r;
      s2_job_r           <= s1_job_r;
      s3_job_r           <= s3_job_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rwcs_queue.sv
`default_nettype none
module rwcs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rwcs_pkg::job_t push_job,
  input  wire logic           pop,
  output rwcs_pkg::job_t      pop_job,
  output logic                full,
  output logic                empty
);

  rwcs_pkg::job_t mem_r [rwcs_pkg::QUEUE_DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full    = cnt_r == 3'(rwcs_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == 3'd0;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule
`default_nettype wire

FILE: rtl/core/rwcs_back.sv
`default_nettype none
module rwcs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rwcs_pkg::job_t pop_job,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rwcs_pkg::out_data_t out_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ACC_RD   = 3'd1;
  localparam logic [2:0] ST_ACC_WR   = 3'd2;
  localparam logic [2:0] ST_EMIT_RD  = 3'd3;
  localparam logic [2:0] ST_EMIT_OUT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  xorig_r, xorig_nxt, xm_r, xm_nxt, ym_r, ym_nxt;
  logic [47:0] contrib_r, contrib_nxt;
  logic        eof_r, eof_nxt;
  logic [3:0]  nx_r, nx_nxt, ny_r, ny_nxt;
  logic [2:0]  ci_r, ci_nxt, cj_r, cj_nxt;
  logic [62:0] mem [64];
  logic [63:0] valid_r;
  logic [62:0] rdata_r;
  logic        rvalid_r;
  logic        rd_en, wr_en, clr_all, out_load, emit_last;
  logic [5:0]  rd_addr;
  logic [62:0] old_sum, new_sum;
  logic [63:0] sum;
  logic [7:0]  xrem, yrem;
  logic        out_valid_r;
  rwcs_pkg::out_data_t out_r;

  assign old_sum   = rvalid_r ? rdata_r : 63'd0;
  assign sum       = {1'b0, old_sum} + {16'd0, contrib_r};
  assign new_sum   = sum[63] ? rwcs_pkg::SUM_MAX : sum[62:0];
  assign xrem      = xm_r & ~(8'd1 << ci_r);
  assign yrem      = ym_r & ~(8'd1 << cj_r);
  assign emit_last = ({1'b0, ci_r} + 4'd1 == nx_r) && ({1'b0, cj_r} + 4'd1 == ny_r);
  assign out_load  = (state_r == ST_EMIT_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt   = state_r;
    xorig_nxt   = xorig_r;
    xm_nxt      = xm_r;
    ym_nxt      = ym_r;
    contrib_nxt = contrib_r;
    eof_nxt     = eof_r;
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    pop         = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = {cj_r, ci_r};
    wr_en       = 1'b0;
    clr_all     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop         = 1'b1;
          xorig_nxt   = pop_job.x_mask;
          xm_nxt      = pop_job.x_mask;
          ym_nxt      = pop_job.y_mask;
          contrib_nxt = pop_job.contrib;
          eof_nxt     = pop_job.frame_end;
          nx_nxt      = pop_job.nx;
          ny_nxt      = pop_job.ny;
          if (pop_job.x_mask != 8'd0 && pop_job.y_mask != 8'd0) begin
            state_nxt = ST_ACC_RD;
          end else if (pop_job.frame_end) begin
            ci_nxt = 3'd0;
            cj_nxt = 3'd0;
            if (pop_job.nx == 4'd0 || pop_job.ny == 4'd0) begin
              clr_all = 1'b1;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end
      ST_ACC_RD: begin
        ci_nxt    = rwcs_pkg::lsb_idx(xm_r);
        cj_nxt    = rwcs_pkg::lsb_idx(ym_r);
        rd_en     = 1'b1;
        rd_addr   = {cj_nxt, ci_nxt};
        state_nxt = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        wr_en = 1'b1;
        if (xrem != 8'd0) begin
          xm_nxt    = xrem;
          state_nxt = ST_ACC_RD;
        end else if (yrem != 8'd0) begin
          xm_nxt    = xorig_r;
          ym_nxt    = yrem;
          state_nxt = ST_ACC_RD;
        end else if (eof_r) begin
          ci_nxt = 3'd0;
          cj_nxt = 3'd0;
          if (nx_r == 4'd0 || ny_r == 4'd0) begin
            clr_all   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_load) begin
          if (emit_last) begin
            clr_all   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if ({1'b0, ci_r} + 4'd1 == nx_r) begin
              ci_nxt = 3'd0;
              cj_nxt = cj_r + 3'd1;
            end else begin
              ci_nxt = ci_r + 3'd1;
            end
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_all) begin
        valid_r <= 64'd0;
      end else if (wr_en) begin
        valid_r[{cj_r, ci_r}] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    xorig_r   <= xorig_nxt;
    xm_r      <= xm_nxt;
    ym_r      <= ym_nxt;
    contrib_r <= contrib_nxt;
    eof_r     <= eof_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    ci_r      <= ci_nxt;
    cj_r      <= cj_nxt;
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
    if (wr_en) mem[{cj_r, ci_r}] <= new_sum;
    if (out_load) begin
      out_r.region_col  <= ci_r;
      out_r.region_row  <= cj_r;
      out_r.chi_square  <= old_sum;
      out_r.last_of_run <= emit_last;
    end
  end

endmodule
`default_nettype wire
